// ----- rtl/sfir_pkg.sv -----
// sfir_pkg: types and constants of the windowed-sinc tap generator
// holds field widths, register index codes, sine polynomial coefficients
// depends on nothing
package sfir_pkg;

	localparam int unsigned IDX_W  = 6;
	localparam int unsigned CNT_W  = 7;
	localparam int unsigned CUT_W  = 16;
	localparam int unsigned COEF_W = 18;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned X_W    = 15;
	localparam int unsigned T2_W   = 29;
	localparam int unsigned ACC_W  = 31;
	localparam int unsigned PROD_W = 60;
	localparam int unsigned V_W    = 63;
	localparam int unsigned M_W    = 62;
	localparam int unsigned DV_W   = 7;
	localparam int unsigned NSTEP  = 5;

	// register index codes
	typedef enum logic [1:0] {
		REG_FILTER_MODE  = 2'd0,
		REG_CUTOFF_UPPER = 2'd1,
		REG_CUTOFF_LOWER = 2'd2,
		REG_TAP_COUNT    = 2'd3
	} cfg_reg_t;

	// mode bits
	localparam int unsigned MODE_HP_BIT = 0;
	localparam int unsigned MODE_BP_BIT = 1;

	// sine polynomial in Q30, Horner order after the top coefficient
	localparam logic [ACC_W-1:0] SIN_A11 = 31'd3864;
	localparam logic [ACC_W-1:0] SIN_COEF [NSTEP] = '{
		31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
	};
	localparam logic [28:0] INV_PI_Q30 = 29'd341782638;

	localparam logic [X_W-1:0] QUARTER = 15'd16384;

	localparam int COEF_MAX = 131071;
	localparam int COEF_MIN = -131072;

	// side info that rides along with each request
	typedef struct packed {
		logic             oor;
		logic             last;
		logic             centre;
		logic [IDX_W-1:0] ad;
	} sfir_side_t;

endpackage

// ----- rtl/sinc_fir_tap_generator.sv -----
// sinc_fir_tap_generator: one windowed-sinc FIR tap per request, fully pipelined
// one request per cycle while no held result stalls the pipeline, with the five Horner
// multiply stages and the one-bit-per-stage restoring divider in its path
// a stalled result freezes the whole pipeline; nothing is lost or repeated
// reset clears all valid bits and loads the register defaults (0, 8192, 4096, 31)
module sinc_fir_tap_generator #(
	parameter int MAX_TAPS  = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  sfir_pkg::cfg_reg_t               cfg_index,
	input  logic [sfir_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [sfir_pkg::IDX_W-1:0]       tap_index,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic signed [sfir_pkg::COEF_W-1:0] coefficient,
	output logic                             last_tap,
	output logic                             out_of_range
);
	import sfir_pkg::*;

	localparam int H_SH = 60 - FRAC_BITS - 1;
	localparam int H_W  = M_W - H_SH;
	localparam int N_W  = H_W + 1;

	// configuration registers
	logic [1:0]       filter_mode_q;
	logic [CUT_W-1:0] cutoff_upper_q;
	logic [CUT_W-1:0] cutoff_lower_q;
	logic [CNT_W-1:0] tap_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q  <= 2'd0;
			cutoff_upper_q <= 16'd8192;
			cutoff_lower_q <= 16'd4096;
			tap_count_q    <= 7'd31;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FILTER_MODE:  filter_mode_q  <= cfg_data[1:0];
				REG_CUTOFF_UPPER: cutoff_upper_q <= cfg_data;
				REG_CUTOFF_LOWER: cutoff_lower_q <= cfg_data;
				REG_TAP_COUNT:    tap_count_q    <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// global advance: everything moves unless a result is held
	logic adv;
	logic res_valid_q;
	assign adv       = !(res_valid_q && res_stall);
	assign req_stall = !adv;

	// stage 1: offset from centre, flags, phases
	logic [CNT_W-1:0] count;
	logic [IDX_W-1:0] mid;
	logic [CNT_W-1:0] idx_ext;
	logic [IDX_W-1:0] ad;
	logic [21:0]      pu_full, pl_full;
	sfir_side_t       side_in;

	always_comb begin
		count = ({25'd0, tap_count_q} > MAX_TAPS) ? CNT_W'(MAX_TAPS) : tap_count_q;
		mid = count[CNT_W-1:1];
		idx_ext = {1'b0, tap_index};
		ad = (tap_index >= mid) ? tap_index - mid : mid - tap_index;
		side_in.oor = idx_ext >= count;
		side_in.last = !side_in.oor && (idx_ext == count - 7'd1);
		side_in.centre = ad == '0;
		side_in.ad = ad;
		pu_full = {6'd0, cutoff_upper_q} * {16'd0, ad};
		pl_full = {6'd0, cutoff_lower_q} * {16'd0, ad};
	end

	logic             vld_s1;
	sfir_side_t       side_s1;
	logic [15:0]      ph_s1 [2];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1  <= side_in;
			ph_s1[0] <= pu_full[15:0];
			ph_s1[1] <= pl_full[15:0];
		end
	end

	// stage 2: quarter-wave fold and x squared, lands in Horner slot 0
	logic [ACC_W-1:0] hn_acc_s  [NSTEP+1][2];
	logic [X_W-1:0]   hn_x_s    [NSTEP+1][2];
	logic [T2_W-1:0]  hn_t2_s   [NSTEP+1][2];
	logic             hn_neg_s  [NSTEP+1][2];
	sfir_side_t       hn_side_s [NSTEP+1];
	logic             hn_vld_s  [NSTEP+1];

	logic [X_W-1:0]   fold_x [2];
	logic [29:0]      fold_sq [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			fold_x[l] = ph_s1[l][14] ? QUARTER - {1'b0, ph_s1[l][13:0]}
			                         : {1'b0, ph_s1[l][13:0]};
			fold_sq[l] = fold_x[l] * fold_x[l];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hn_side_s[0] <= side_s1;
			for (int l = 0; l < 2; l++) begin
				hn_acc_s[0][l] <= SIN_A11;
				hn_x_s[0][l]   <= fold_x[l];
				hn_t2_s[0][l]  <= fold_sq[l][T2_W-1:0];
				hn_neg_s[0][l] <= ph_s1[l][15];
			end
		end
	end

	// Horner steps: acc = a - (acc * x^2 >> 28), one multiply per stage
	for (genvar k = 0; k < NSTEP; k++) begin : g_horner
		logic [59:0] prod [2];
		logic [31:0] nxt  [2];
		always_comb begin
			for (int l = 0; l < 2; l++) begin
				prod[l] = {29'd0, hn_acc_s[k][l]} * {31'd0, hn_t2_s[k][l]};
				nxt[l]  = {1'b0, SIN_COEF[k]} - prod[l][59:28];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				hn_side_s[k+1] <= hn_side_s[k];
				for (int l = 0; l < 2; l++) begin
					hn_acc_s[k+1][l] <= nxt[l][ACC_W-1:0];
					hn_x_s[k+1][l]   <= hn_x_s[k][l];
					hn_t2_s[k+1][l]  <= hn_t2_s[k][l];
					hn_neg_s[k+1][l] <= hn_neg_s[k][l];
				end
			end
		end
	end

	// magnitude: acc * x >> 14
	logic [45:0]      mag_full [2];
	logic [ACC_W-1:0] mag_s8   [2];
	logic             neg_s8   [2];
	sfir_side_t       side_s8;
	logic             vld_s8;

	always_comb begin
		for (int l = 0; l < 2; l++)
			mag_full[l] = {15'd0, hn_acc_s[NSTEP][l]} * {31'd0, hn_x_s[NSTEP][l]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s8 <= hn_side_s[NSTEP];
			for (int l = 0; l < 2; l++) begin
				mag_s8[l] <= mag_full[l][44:14];
				neg_s8[l] <= hn_neg_s[NSTEP][l];
			end
		end
	end

	// scale by 1/pi into Q60
	logic [PROD_W-1:0] prod_s9 [2];
	logic              neg_s9  [2];
	sfir_side_t        side_s9;
	logic              vld_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s9 <= side_s8;
			for (int l = 0; l < 2; l++) begin
				prod_s9[l] <= {29'd0, mag_s8[l]} * {31'd0, INV_PI_Q30};
				neg_s9[l]  <= neg_s8[l];
			end
		end
	end

	// signed terms, high-pass sign folded in, centre value formed
	logic                    hp_mode;
	logic signed [18:0]      ctr_x;
	logic signed [PROD_W:0]  term_s10 [2];
	logic signed [V_W-1:0]   ctr_s10;
	sfir_side_t              side_s10;
	logic                    vld_s10;

	always_comb begin
		hp_mode = !filter_mode_q[MODE_BP_BIT] && filter_mode_q[MODE_HP_BIT];
		if (filter_mode_q[MODE_BP_BIT])
			ctr_x = $signed({2'b0, cutoff_upper_q, 1'b0}) - $signed({2'b0, cutoff_lower_q, 1'b0});
		else if (filter_mode_q[MODE_HP_BIT])
			ctr_x = 19'sd65536 - $signed({2'b0, cutoff_upper_q, 1'b0});
		else
			ctr_x = $signed({2'b0, cutoff_upper_q, 1'b0});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s10 <= side_s9;
			ctr_s10  <= {ctr_x, 44'd0};
			term_s10[0] <= (neg_s9[0] ^ hp_mode) ? -$signed({1'b0, prod_s9[0]})
			                                     : $signed({1'b0, prod_s9[0]});
			term_s10[1] <= neg_s9[1] ? -$signed({1'b0, prod_s9[1]})
			                         : $signed({1'b0, prod_s9[1]});
		end
	end

	// combine lanes into the Q60 numerator
	logic signed [V_W-1:0] v_s11;
	sfir_side_t            side_s11;
	logic                  vld_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s11 <= side_s10;
			if (side_s10.centre)
				v_s11 <= ctr_s10;
			else if (filter_mode_q[MODE_BP_BIT])
				v_s11 <= V_W'(term_s10[0]) - V_W'(term_s10[1]);
			else
				v_s11 <= V_W'(term_s10[0]);
		end
	end

	// magnitude, rounding fold: q = floor((m >> sh-1) + ad) / (2 ad)
	logic [V_W-1:0]   absv;
	logic [IDX_W-1:0] ad_eff;
	logic [N_W-1:0]   num_in;

	logic [DV_W-1:0]  dv_rem_s  [N_W+1];
	logic [N_W-1:0]   dv_num_s  [N_W+1];
	logic [N_W-1:0]   dv_quo_s  [N_W+1];
	logic [DV_W-1:0]  dv_den_s  [N_W+1];
	logic             dv_neg_s  [N_W+1];
	sfir_side_t       dv_side_s [N_W+1];
	logic             dv_vld_s  [N_W+1];

	always_comb begin
		absv   = v_s11[V_W-1] ? -v_s11 : v_s11;
		ad_eff = side_s11.centre ? IDX_W'(1) : side_s11.ad;
		num_in = {1'b0, absv[M_W-1:H_SH]} + N_W'(ad_eff);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_side_s[0] <= side_s11;
			dv_rem_s[0]  <= '0;
			dv_num_s[0]  <= num_in;
			dv_quo_s[0]  <= '0;
			dv_den_s[0]  <= {ad_eff, 1'b0};
			dv_neg_s[0]  <= v_s11[V_W-1];
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar j = 0; j < N_W; j++) begin : g_div
		logic [DV_W:0] trial;
		logic          ge;
		logic [DV_W:0] diff;
		always_comb begin
			trial = {dv_rem_s[j], dv_num_s[j][N_W-1-j]};
			ge    = trial >= {1'b0, dv_den_s[j]};
			diff  = trial - {1'b0, dv_den_s[j]};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_side_s[j+1] <= dv_side_s[j];
				dv_num_s[j+1]  <= dv_num_s[j];
				dv_den_s[j+1]  <= dv_den_s[j];
				dv_neg_s[j+1]  <= dv_neg_s[j];
				dv_rem_s[j+1]  <= ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
				dv_quo_s[j+1]  <= dv_quo_s[j] | (N_W'(ge) << (N_W-1-j));
			end
		end
	end

	// saturate and zero for out-of-range
	logic [31:0]              q_ext;
	logic signed [COEF_W-1:0] coef_nxt;
	sfir_side_t               fin;

	always_comb begin
		fin   = dv_side_s[N_W];
		q_ext = 32'(dv_quo_s[N_W]);
		if (fin.oor)
			coef_nxt = '0;
		else if (dv_neg_s[N_W])
			coef_nxt = (q_ext > 32'(-COEF_MIN)) ? COEF_W'(COEF_MIN) : -COEF_W'(q_ext);
		else
			coef_nxt = (q_ext > 32'(COEF_MAX)) ? COEF_W'(COEF_MAX) : COEF_W'(q_ext);
	end

	logic signed [COEF_W-1:0] coef_q;
	logic                     last_q;
	logic                     oor_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			coef_q <= coef_nxt;
			last_q <= fin.last;
			oor_q  <= fin.oor;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s8      <= 1'b0;
			vld_s9      <= 1'b0;
			vld_s10     <= 1'b0;
			vld_s11     <= 1'b0;
			res_valid_q <= 1'b0;
			for (int k = 0; k <= NSTEP; k++) hn_vld_s[k] <= 1'b0;
			for (int j = 0; j <= N_W; j++) dv_vld_s[j] <= 1'b0;
		end else if (adv) begin
			vld_s1      <= req_valid;
			hn_vld_s[0] <= vld_s1;
			for (int k = 0; k < NSTEP; k++) hn_vld_s[k+1] <= hn_vld_s[k];
			vld_s8      <= hn_vld_s[NSTEP];
			vld_s9      <= vld_s8;
			vld_s10     <= vld_s9;
			vld_s11     <= vld_s10;
			dv_vld_s[0] <= vld_s11;
			for (int j = 0; j < N_W; j++) dv_vld_s[j+1] <= dv_vld_s[j];
			res_valid_q <= dv_vld_s[N_W];
		end
	end

	assign res_valid    = res_valid_q;
	assign coefficient  = coef_q;
	assign last_tap     = last_q;
	assign out_of_range = oor_q;

endmodule

// ----- rtl/sfir_checker.sv -----
// sfir_port_checks: port-level checks of the tap generator, bound to the top level
// depends on sfir_pkg and sinc_fir_tap_generator
module sfir_port_checks (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	input  logic                               req_stall,
	input  logic                               res_valid,
	input  logic                               res_stall,
	input  logic signed [sfir_pkg::COEF_W-1:0] coefficient,
	input  logic                               last_tap,
	input  logic                               out_of_range
);
	import sfir_pkg::*;

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(coefficient) && $stable(last_tap))
		else $error("held result changed");

	// requests are only stalled while a result is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> res_valid && res_stall)
		else $error("request stalled without output backpressure");

	// out-of-range index gives zero
	a_oor: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_of_range |-> coefficient == '0 && !last_tap)
		else $error("out-of-range result not zero");

	// last tap is always an in-range index
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last_tap |-> !out_of_range)
		else $error("last tap flagged out of range");

endmodule

bind sinc_fir_tap_generator sfir_port_checks u_sfir_port_checks (.*);

// ----- tb/sfir_checker.sv -----
// sfir_checker: watches the request and result channels of the tap generator
// predicts each coefficient from its own copy of the registers and compares
// depends on sfir_pkg
module sfir_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  sfir_pkg::cfg_reg_t                  cfg_index,
	input  logic [sfir_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                req_valid,
	input  logic                                req_stall,
	input  logic [sfir_pkg::IDX_W-1:0]          tap_index,
	input  logic                                res_valid,
	input  logic                                res_stall,
	input  logic signed [sfir_pkg::COEF_W-1:0]  coefficient,
	input  logic                                last_tap,
	input  logic                                out_of_range,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import sfir_pkg::*;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef;
		logic                     last;
		logic                     oor;
	} tap_result_t;

	logic [1:0]       mode_q;
	logic [CUT_W-1:0] fhi_q;
	logic [CUT_W-1:0] flo_q;
	logic [CNT_W-1:0] ntaps_q;
	tap_result_t      coef_queue[$];

	// sine magnitude of a Q0.16 phase, Q30, sign returned separately
	function automatic longint unsigned quarter_sine(input logic [15:0] ph, output bit neg);
		longint unsigned x, t2, acc;
		logic [1:0] quad;
		quad = ph[15:14];
		x = ph[13:0];
		if (quad[0]) x = 16384 - x;
		t2 = x * x;
		acc = 3864;
		acc = 64'd172272 - ((acc * t2) >> 28);
		acc = 64'd5026995 - ((acc * t2) >> 28);
		acc = 64'd85569306 - ((acc * t2) >> 28);
		acc = 64'd693598668 - ((acc * t2) >> 28);
		acc = 64'd1686629713 - ((acc * t2) >> 28);
		neg = quad[1];
		return (acc * x) >> 14;
	endfunction

	// sin(2 pi f d)/pi in signed Q60
	function automatic longint edge_term(input logic [15:0] f, input int unsigned ad);
		bit neg;
		logic [31:0] prod;
		longint unsigned num;
		prod = f * ad;
		num = quarter_sine(prod[15:0], neg) * 64'd341782638;
		return neg ? -longint'(num) : longint'(num);
	endfunction

	function automatic tap_result_t predict_tap(input logic [IDX_W-1:0] idx);
		tap_result_t r;
		int unsigned n, mid, ad;
		longint v;
		longint unsigned mag, den, q;
		n = (ntaps_q > 64) ? 64 : ntaps_q;
		r = '0;
		if (idx >= n) begin
			r.oor = 1'b1;
			return r;
		end
		mid = n / 2;
		ad = (idx >= mid) ? idx - mid : mid - idx;
		if (ad == 0) begin
			if (mode_q[MODE_BP_BIT]) v = (2 * longint'(fhi_q) - 2 * longint'(flo_q)) <<< 44;
			else if (mode_q[MODE_HP_BIT]) v = (65536 - 2 * longint'(fhi_q)) <<< 44;
			else v = (2 * longint'(fhi_q)) <<< 44;
			den = 64'd1 << 44;
		end else begin
			if (mode_q[MODE_BP_BIT]) v = edge_term(fhi_q, ad) - edge_term(flo_q, ad);
			else if (mode_q[MODE_HP_BIT]) v = -edge_term(fhi_q, ad);
			else v = edge_term(fhi_q, ad);
			den = longint'(ad) << 44;
		end
		mag = (v < 0) ? -v : v;
		q = (mag + den / 2) / den;
		if (v < 0) r.coef = (q > 131072) ? COEF_MIN : -longint'(q);
		else r.coef = (q > COEF_MAX) ? COEF_MAX : q;
		r.last = (idx == n - 1);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	// register shadow, requests, and result comparison
	always @(posedge clk or negedge arst_n) begin
		tap_result_t want;
		if (!arst_n) begin
			mode_q <= 2'd0;
			fhi_q <= 16'd8192;
			flo_q <= 16'd4096;
			ntaps_q <= 7'd31;
			coef_queue.delete();
			fail_count = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_FILTER_MODE: mode_q <= cfg_data[1:0];
					REG_CUTOFF_UPPER: fhi_q <= cfg_data;
					REG_CUTOFF_LOWER: flo_q <= cfg_data;
					REG_TAP_COUNT: ntaps_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (req_valid && !req_stall) coef_queue.push_back(predict_tap(tap_index));
			if (res_valid && !res_stall) begin
				checked++;
				if (coef_queue.size() == 0) begin
					report_mismatch("unexpected result, coefficient", coefficient, 0);
				end else begin
					want = coef_queue.pop_front();
					if (coefficient !== want.coef)
						report_mismatch("coefficient", coefficient, want.coef);
					if (last_tap !== want.last)
						report_mismatch("last_tap", last_tap, want.last);
					if (out_of_range !== want.oor)
						report_mismatch("out_of_range", out_of_range, want.oor);
				end
			end
			pending = coef_queue.size();
		end
	end
endmodule

// ----- tb/tb_top.sv -----
// tb_top: stimulus and verdict for the windowed-sinc tap generator
// directed taps then random requests over several filter settings
// depends on sfir_pkg, sinc_fir_tap_generator and sfir_checker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sfir_pkg::*;

	localparam int LATENCY = 33;
	localparam longint CYCLE_LIMIT = 200000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	cfg_reg_t           cfg_index = REG_FILTER_MODE;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [IDX_W-1:0]   tap_index = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic signed [COEF_W-1:0] coefficient;
	logic               last_tap;
	logic               out_of_range;
	int                 fail_count, pending, checked;
	longint             cycles = 0;
	bit                 calm = 1'b0;
	int                 settings_run = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sinc_fir_tap_generator dut (.*);

	sfir_checker u_checker (.*);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side stalls at random, none while calm
	always @(negedge clk) begin
		res_stall <= !calm && ($urandom_range(99) < 17);
	end

	// one register write; the caller drops the write enable after the last one
	task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
		cfg_index <= r;
		cfg_data <= v;
		cfg_write <= 1'b1;
		@(negedge clk);
	endtask

	// send one request, with a random gap beforehand; valid is left for the next step
	task automatic send_tap(input logic [IDX_W-1:0] idx);
		while (!calm && $urandom_range(99) < 17) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		tap_index <= idx;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain;
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 3) @(negedge clk);
	endtask

	task automatic set_filter(input logic [1:0] m, input logic [15:0] fh,
			input logic [15:0] fl, input logic [6:0] n);
		drain();
		write_reg(REG_FILTER_MODE, CFG_W'(m));
		write_reg(REG_CUTOFF_UPPER, fh);
		write_reg(REG_CUTOFF_LOWER, fl);
		write_reg(REG_TAP_COUNT, CFG_W'(n));
		cfg_write <= 1'b0;
		settings_run++;
	endtask

	initial begin
		int n;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset defaults, edges of the index field
		send_tap(0); send_tap(15); send_tap(30); send_tap(31); send_tap(63);
		// high-pass, cutoff at one half, largest count
		set_filter(2'd1, 16'd32768, 16'd0, 7'd64);
		send_tap(0); send_tap(32); send_tap(63); send_tap(33);
		// band-pass with zero and half edges, count above the limit
		set_filter(2'd2, 16'd32768, 16'd0, 7'd127);
		send_tap(32); send_tap(31); send_tap(63); send_tap(0);
		// mode three, cutoffs above one half, count of one
		set_filter(2'd3, 16'hFFFF, 16'hFFFF, 7'd1);
		send_tap(0); send_tap(1);
		// zero count: all out of range
		set_filter(2'd0, 16'd0, 16'd32768, 7'd0);
		send_tap(0); send_tap(42);
		// low-pass, small cutoff, even count
		set_filter(2'd0, 16'd1, 16'd2, 7'd2);
		send_tap(0); send_tap(1); send_tap(2);

		// random phases, one of them with no idling at all
		for (int ph = 0; ph < 10; ph++) begin
			calm = (ph == 4);
			set_filter(2'($urandom_range(3)),
				16'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(32768)),
				16'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(32768)),
				7'(($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(1, 64)));
			for (int k = 0; k < 50; k++) begin
				n = (u_checker.ntaps_q > 64) ? 64 : u_checker.ntaps_q;
				if ($urandom_range(9) == 0 || n == 0) send_tap(IDX_W'($urandom_range(63)));
				else send_tap(IDX_W'($urandom_range(n - 1)));
			end
		end
		calm = 1'b0;

		drain();
		$display("covered %0d filter settings, %0d taps checked", settings_run, checked);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

// ----- files.f -----
rtl/sfir_pkg.sv
rtl/sinc_fir_tap_generator.sv
rtl/sfir_checker.sv
tb/sfir_checker.sv
tb/tb_top.sv
